// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the compensation rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ptc_pkg.sv =====
// shared widths, types and reciprocal table for the compensation pipeline
package ptc_pkg;

  localparam int RAW_W    = 24;
  localparam int FRAC_W   = 24;              // fraction bits of scaled p and t
  localparam int SC_SHIFT = 24;              // shift that takes raw times reciprocal to FRAC_W fraction bits
  localparam int RCP_W    = 32;
  localparam int OSR_W    = 3;
  localparam int SPROD_W  = RAW_W + RCP_W;
  localparam int P_W      = 31;              // |p|, |t| stay below 2^30
  localparam int PC_W     = P_W + 16;
  localparam int TPF_W    = 2 * P_W;
  localparam int TC1F_W   = P_W + 12;
  localparam int TMS_W    = TC1F_W + 1;
  localparam int A2_W     = 46;
  localparam int TP_W     = 36;
  localparam int TC01_SH  = FRAC_W - 6;
  localparam int TC01R_W  = 28;
  localparam int TM_SH    = FRAC_W - 8;
  localparam int TM_W     = 27;
  localparam int MA_W     = 37;
  localparam int MB_W     = 51;
  localparam int ML_W     = 26;              // low slice of the wide operand
  localparam int MP_W     = MA_W + MB_W;
  localparam int A1_W     = 51;
  localparam int PP_SH    = 2 * FRAC_W - 6;
  localparam int PPR_W    = 38;
  localparam int PART0_W  = 29;
  localparam int PART_W   = 40;
  localparam int PR_W     = 41;
  localparam int OUTP_W   = 32;
  localparam int OUTT_W   = 24;
  localparam int NST      = 11;              // register stages, last is the output
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_COEFFS  = 3'd0,
    REG_PRESS_A      = 3'd1,
    REG_PRESS_B      = 3'd2,
    REG_PRESS_C      = 3'd3,
    REG_PRESS_OSR    = 3'd4,
    REG_TEMP_OSR     = 3'd5
  } ptc_reg_e;

  typedef struct packed {
    logic [11:0]      c0;
    logic [11:0]      c1;
    logic [19:0]      c00;
    logic [19:0]      c10;
    logic [15:0]      c01;
    logic [15:0]      c11;
    logic [15:0]      c20;
    logic [15:0]      c21;
    logic [15:0]      c30;
    logic [OSR_W-1:0] p_osr;
    logic [OSR_W-1:0] t_osr;
  } ptc_cfg_t;

  typedef struct packed {
    logic [P_W-1:0]     p;
    logic [A2_W-1:0]    a2;
    logic [A2_W-1:0]    b;
    logic [TP_W-1:0]    tp;
    logic [TC01R_W-1:0] tc01r;
    logic [TM_W-1:0]    tm;
  } ptc_front_t;

  // round(2^48 / k) for each oversampling scale factor k
  function automatic logic [RCP_W-1:0] recip(logic [OSR_W-1:0] code);
    logic [RCP_W-1:0] r;
    case (code)
      3'd0:    r = 32'd536870912;
      3'd1:    r = 32'd178956971;
      3'd2:    r = 32'd76695845;
      3'd3:    r = 32'd35791394;
      3'd4:    r = 32'd1108378657;
      3'd5:    r = 32'd545392673;
      3'd6:    r = 32'd270549121;
      3'd7:    r = 32'd134744072;
      default: r = 32'd536870912;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ptc_wide_mul.sv =====
// two-stage signed multiplier split into two partial products
module ptc_wide_mul (
  input  logic                                 clk_i,
  input  logic [1:0]                           en_i,
  input  logic signed [ptc_pkg::MA_W-1:0]      a_i,
  input  logic signed [ptc_pkg::MB_W-1:0]      b_i,
  output logic signed [ptc_pkg::MP_W-1:0]      prod_o
);
  import ptc_pkg::*;

  logic signed [MA_W+ML_W:0]           pp_lo_q;
  logic signed [MA_W+MB_W-ML_W-1:0]    pp_hi_q;
  logic signed [MP_W-1:0]              prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_lo_q <= a_i * $signed({1'b0, b_i[ML_W-1:0]});
      pp_hi_q <= a_i * $signed(b_i[MB_W-1:ML_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= (MP_W'(pp_hi_q) <<< ML_W) + MP_W'(pp_lo_q);
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/ptc_front.sv =====
// front stages: raw scaling, short products, a2/b/tp terms and temperature
module ptc_front (
  input  logic                                 clk_i,
  input  logic [3:0]                           en_i,
  input  logic signed [ptc_pkg::RAW_W-1:0]     raw_p_i,
  input  logic signed [ptc_pkg::RAW_W-1:0]     raw_t_i,
  input  ptc_pkg::ptc_cfg_t                    cfg_i,
  output ptc_pkg::ptc_front_t                  res_o
);
  import ptc_pkg::*;

  localparam logic signed [SPROD_W-1:0] SC_HALF   = SPROD_W'(1) << (SC_SHIFT - 1);
  localparam logic signed [TPF_W-1:0]   TP_HALF   = TPF_W'(1) << (FRAC_W - 1);
  localparam logic signed [PC_W-1:0]    TC01_HALF = PC_W'(1) << (TC01_SH - 1);
  localparam logic signed [TMS_W-1:0]   TM_HALF   = TMS_W'(1) << (TM_SH - 1);

  logic signed [SPROD_W-1:0] sp_q, st_q, sp_rnd, st_rnd;
  logic signed [P_W-1:0]     p1_q, t1_q, p2_q;
  logic signed [PC_W-1:0]    pc30_q, pc21_q, tc01f_q;
  logic signed [TPF_W-1:0]   tpf_q, tp_rnd;
  logic signed [TC1F_W-1:0]  tc1f_q;
  logic signed [PC_W-1:0]    a2_sum, b_sum, tc01_rnd;
  logic signed [TMS_W-1:0]   tm_sum;
  ptc_front_t                res_d, res_q;

  // stage 0: raw reading times reciprocal of the scale factor
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sp_q <= raw_p_i * $signed(recip(cfg_i.p_osr));
      st_q <= raw_t_i * $signed(recip(cfg_i.t_osr));
    end
  end

  // round half away from zero: add half, take one off when negative
  always_comb begin
    sp_rnd = sp_q + SC_HALF - $signed({1'b0, sp_q[SPROD_W-1]});
    st_rnd = st_q + SC_HALF - $signed({1'b0, st_q[SPROD_W-1]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p1_q <= sp_rnd[SC_SHIFT +: P_W];
      t1_q <= st_rnd[SC_SHIFT +: P_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pc30_q  <= p1_q * $signed(cfg_i.c30);
      pc21_q  <= p1_q * $signed(cfg_i.c21);
      tpf_q   <= t1_q * p1_q;
      tc01f_q <= t1_q * $signed(cfg_i.c01);
      tc1f_q  <= t1_q * $signed(cfg_i.c1);
      p2_q    <= p1_q;
    end
  end

  always_comb begin
    a2_sum   = $signed({cfg_i.c20, {FRAC_W{1'b0}}}) + pc30_q;
    b_sum    = $signed({cfg_i.c11, {FRAC_W{1'b0}}}) + pc21_q;
    tp_rnd   = tpf_q + TP_HALF - $signed({1'b0, tpf_q[TPF_W-1]});
    tc01_rnd = tc01f_q + TC01_HALF - $signed({1'b0, tc01f_q[PC_W-1]});
    // c0 * 128 is folded in ahead of the shift
    tm_sum   = tc1f_q + $signed({cfg_i.c0, {(TM_SH + 7){1'b0}}}) + TM_HALF
             - $signed({1'b0, tc1f_q[TC1F_W-1]});
    res_d.p     = p2_q;
    res_d.a2    = a2_sum[A2_W-1:0];
    res_d.b     = b_sum[A2_W-1:0];
    res_d.tp    = tp_rnd[FRAC_W +: TP_W];
    res_d.tc01r = tc01_rnd[TC01_SH +: TC01R_W];
    res_d.tm    = tm_sum[TM_SH +: TM_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/pressure_temperature_compensation.sv =====
// Barometric pressure and temperature compensation pipeline.
// Slave stream: one beat carries a raw pressure and a raw temperature reading
// (signed 24-bit each); the block returns one beat per input on the master
// stream with compensated pressure (1/64 Pa), temperature (1/256 C) and a
// saturation flag in tuser. Coefficients and oversampling codes are loaded
// through the register write port; the user must do so only while no beats
// are in flight (the block does not enforce it). The datapath is an 11-stage
// register pipeline: scaling by reciprocal, short products, then three wide
// products each split into two partial products over two stages. One beat
// per cycle is sustained while m_axis_tready stays high.
// Every stage moves when it is empty or the stage after it moves, so bubbles
// are squeezed out and inputs are still taken while a result waits on the
// master side; s_axis_tready drops only once every stage holds a beat and
// m_axis_tready is low. Nothing is dropped or repeated across stalls.
// Reset empties the pipeline and clears all coefficient registers to zero.
`include "assert_macros.svh"

module pressure_temperature_compensation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // raw_pressure [23:0], raw_temperature [47:24]
  input  logic [2*ptc_pkg::RAW_W-1:0]          s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // pressure_out [31:0], temperature_out [55:32]
  output logic [ptc_pkg::OUTP_W+ptc_pkg::OUTT_W-1:0] m_axis_tdata,
  // saturated [0]
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ptc_pkg::CFG_W-1:0]            cfg_wdata_i
);
  import ptc_pkg::*;

  localparam logic signed [MP_W-1:0] HALF_F  = MP_W'(1) << (FRAC_W - 1);
  localparam logic signed [MP_W-1:0] HALF_PP = MP_W'(1) << (PP_SH - 1);

  logic [23:0]      temp_coeffs_q;
  logic [39:0]      press_a_q;
  logic [31:0]      press_b_q;
  logic [47:0]      press_c_q;
  logic [OSR_W-1:0] press_osr_q, temp_osr_q;
  ptc_cfg_t         cfg;

  logic [NST-1:0]   v_q, v_d, en, v_prev;
  ptc_front_t       fr;

  logic signed [MP_W-1:0]    pa2, tpb, pa1, a1_sum, tpb_sum, pa1_sum;
  logic signed [P_W-1:0]     p4_q, p5_q, p6_q;
  logic signed [TC01R_W-1:0] tc01r4_q, tc01r5_q;
  logic signed [TM_W-1:0]    tm4_q, tm5_q, tm6_q, tm7_q, tm8_q, tm9_q;
  logic signed [A1_W-1:0]    a1_q;
  logic signed [PPR_W-1:0]   tpbr_q, pa1r_q;
  logic signed [PART0_W-1:0] part0_q;
  logic signed [PART_W-1:0]  part7_q, part8_q, part9_q;
  logic signed [PR_W-1:0]    pr_sum;
  logic                      pr_hi, pr_lo, tm_hi, tm_lo;
  logic [OUTP_W-1:0]         pres_d, pres_q;
  logic [OUTT_W-1:0]         temp_d, temp_q;
  logic                      sat_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      press_c_q     <= '0;
      press_osr_q   <= '0;
      temp_osr_q    <= '0;
    end else if (cfg_we_i) begin
      case (ptc_reg_e'(cfg_idx_i))
        REG_TEMP_COEFFS: temp_coeffs_q <= cfg_wdata_i[23:0];
        REG_PRESS_A:     press_a_q     <= cfg_wdata_i[39:0];
        REG_PRESS_B:     press_b_q     <= cfg_wdata_i[31:0];
        REG_PRESS_C:     press_c_q     <= cfg_wdata_i[47:0];
        REG_PRESS_OSR:   press_osr_q   <= cfg_wdata_i[OSR_W-1:0];
        REG_TEMP_OSR:    temp_osr_q    <= cfg_wdata_i[OSR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.c0    = temp_coeffs_q[23:12];
    cfg.c1    = temp_coeffs_q[11:0];
    cfg.c00   = press_a_q[39:20];
    cfg.c10   = press_a_q[19:0];
    cfg.c01   = press_b_q[31:16];
    cfg.c11   = press_b_q[15:0];
    cfg.c20   = press_c_q[47:32];
    cfg.c21   = press_c_q[31:16];
    cfg.c30   = press_c_q[15:0];
    cfg.p_osr = press_osr_q;
    cfg.t_osr = temp_osr_q;
  end

  // a stage moves when it or any stage after it has a bubble, or the sink takes
  always_comb begin
    for (int i = 0; i < NST; i++) begin
      en[i] = m_axis_tready | ~&(v_q | ~({NST{1'b1}} << i));
    end
    v_prev = {v_q[NST-2:0], s_axis_tvalid};
    v_d    = (en & v_prev) | (~en & v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[0];

  ptc_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[3:0]),
    .raw_p_i ($signed(s_axis_tdata[RAW_W-1:0])),
    .raw_t_i ($signed(s_axis_tdata[2*RAW_W-1:RAW_W])),
    .cfg_i   (cfg),
    .res_o   (fr)
  );

  ptc_wide_mul u_mul_pa2 (
    .clk_i  (clk_i),
    .en_i   (en[5:4]),
    .a_i    (MA_W'($signed(fr.p))),
    .b_i    (MB_W'($signed(fr.a2))),
    .prod_o (pa2)
  );

  ptc_wide_mul u_mul_tpb (
    .clk_i  (clk_i),
    .en_i   (en[5:4]),
    .a_i    (MA_W'($signed(fr.tp))),
    .b_i    (MB_W'($signed(fr.b))),
    .prod_o (tpb)
  );

  // carry the short terms alongside the first wide products
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p4_q     <= $signed(fr.p);
      tc01r4_q <= $signed(fr.tc01r);
      tm4_q    <= $signed(fr.tm);
    end
    if (en[5]) begin
      p5_q     <= p4_q;
      tc01r5_q <= tc01r4_q;
      tm5_q    <= tm4_q;
    end
  end

  // c10 * 2^24 is folded in ahead of the rounding shift
  always_comb begin
    a1_sum  = pa2 + $signed({cfg.c10, {(2*FRAC_W){1'b0}}}) + HALF_F
            - $signed({1'b0, pa2[MP_W-1]});
    tpb_sum = tpb + HALF_PP - $signed({1'b0, tpb[MP_W-1]});
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      a1_q    <= a1_sum[FRAC_W +: A1_W];
      tpbr_q  <= tpb_sum[PP_SH +: PPR_W];
      part0_q <= $signed({cfg.c00, 6'b0}) + tc01r5_q;
      p6_q    <= p5_q;
      tm6_q   <= tm5_q;
    end
  end

  ptc_wide_mul u_mul_pa1 (
    .clk_i  (clk_i),
    .en_i   (en[8:7]),
    .a_i    (MA_W'(p6_q)),
    .b_i    (a1_q),
    .prod_o (pa1)
  );

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      part7_q <= part0_q + tpbr_q;
      tm7_q   <= tm6_q;
    end
    if (en[8]) begin
      part8_q <= part7_q;
      tm8_q   <= tm7_q;
    end
  end

  assign pa1_sum = pa1 + HALF_PP - $signed({1'b0, pa1[MP_W-1]});

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      pa1r_q  <= pa1_sum[PP_SH +: PPR_W];
      part9_q <= part8_q;
      tm9_q   <= tm8_q;
    end
  end

  // final sum and clamp to the output ranges
  always_comb begin
    pr_sum = part9_q + pa1r_q;
    pr_hi  = !pr_sum[PR_W-1] && (|pr_sum[PR_W-2:OUTP_W-1]);
    pr_lo  = pr_sum[PR_W-1] && !(&pr_sum[PR_W-2:OUTP_W-1]);
    tm_hi  = !tm9_q[TM_W-1] && (|tm9_q[TM_W-2:OUTT_W-1]);
    tm_lo  = tm9_q[TM_W-1] && !(&tm9_q[TM_W-2:OUTT_W-1]);
    if (pr_hi) begin
      pres_d = {1'b0, {(OUTP_W-1){1'b1}}};
    end else if (pr_lo) begin
      pres_d = {1'b1, {(OUTP_W-1){1'b0}}};
    end else begin
      pres_d = pr_sum[OUTP_W-1:0];
    end
    if (tm_hi) begin
      temp_d = {1'b0, {(OUTT_W-1){1'b1}}};
    end else if (tm_lo) begin
      temp_d = {1'b1, {(OUTT_W-1){1'b0}}};
    end else begin
      temp_d = tm9_q[OUTT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      pres_q <= pres_d;
      temp_q <= temp_d;
      sat_q  <= pr_hi | pr_lo | tm_hi | tm_lo;
    end
  end

  assign m_axis_tvalid = v_q[NST-1];
  assign m_axis_tdata  = {temp_q, pres_q};
  assign m_axis_tuser  = sat_q;

  `PTC_ASSERT_NEXT(a_in_enters, s_axis_tvalid && s_axis_tready, v_q[0], "accepted beat not in stage 0")
  `PTC_ASSERT_NEXT(a_mid_hold, v_q[5] && !en[5], v_q[5], "stalled stage 5 lost its beat")
  `PTC_ASSERT_NEXT(a_out_fill, v_q[NST-2] && en[NST-1], m_axis_tvalid, "beat lost into output stage")
  `PTC_ASSERT(a_sat_clamp, (m_axis_tvalid && m_axis_tuser) |-> (pres_q == 32'h7fff_ffff || pres_q == 32'h8000_0000 || temp_q == 24'h7f_ffff || temp_q == 24'h80_0000), "saturated flag without clamped value")

endmodule

// ===== tb/sv/compensation_checker.sv =====
// scoreboard for the compensation block: tracks coefficients, predicts readings, compares beats
module compensation_checker (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  input  logic                                       s_axis_tready,
  // raw_pressure [23:0], raw_temperature [47:24]
  input  logic [2*ptc_pkg::RAW_W-1:0]                s_axis_tdata,
  input  logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // pressure_out [31:0], temperature_out [55:32]
  input  logic [ptc_pkg::OUTP_W+ptc_pkg::OUTT_W-1:0] m_axis_tdata,
  // saturated [0]
  input  logic                                       m_axis_tuser,
  input  logic                                       cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [ptc_pkg::CFG_W-1:0]                  cfg_wdata_i,
  output int                                         mismatch_cnt_o,
  output int                                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int FRAC = 24;
  localparam longint ONE = longint'(1) << FRAC;

  typedef struct packed {
    logic [OUTP_W-1:0] pressure;
    logic [OUTT_W-1:0] temperature;
    logic              saturated;
  } reading_t;

  reading_t expected_readings[$];
  ptc_cfg_t coeffs;

  function automatic longint unsigned scale_factor(logic [OSR_W-1:0] code);
    case (code)
      3'd0:    return 64'd524288;
      3'd1:    return 64'd1572864;
      3'd2:    return 64'd3670016;
      3'd3:    return 64'd7864320;
      3'd4:    return 64'd253952;
      3'd5:    return 64'd516096;
      3'd6:    return 64'd1040384;
      default: return 64'd2088960;
    endcase
  endfunction

  // a*b/2^sh rounded half away from zero, magnitude held at 2^61
  function automatic longint round_mul(longint a, longint b, int unsigned sh, inout bit clip);
    logic [127:0] mag;
    logic [63:0]  ua, ub;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    mag = {64'd0, ua} * {64'd0, ub};
    if (sh > 0) mag = (mag + (128'd1 << (sh - 1))) >> sh;
    if (mag > (128'd1 << 61)) begin
      clip = 1'b1;
      mag = 128'd1 << 61;
    end
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint scale_raw(logic [RAW_W-1:0] raw, logic [OSR_W-1:0] code,
                                       inout bit clip);
    longint unsigned k, r;
    k = scale_factor(code);
    r = ((64'd1 << (FRAC + 24)) + k / 2) / k;
    return round_mul($signed(raw), longint'(r), 24, clip);
  endfunction

  function automatic reading_t compensate(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
    longint   c0, c1, c00, c10, c01, c11, c20, c21, c30;
    longint   p, t, a2, a1, b, tp, pr, tm, p_term, t_term, tp_term;
    bit       clip;
    reading_t res;
    clip = 1'b0;
    c0 = $signed(coeffs.c0);
    c1 = $signed(coeffs.c1);
    c00 = $signed(coeffs.c00);
    c10 = $signed(coeffs.c10);
    c01 = $signed(coeffs.c01);
    c11 = $signed(coeffs.c11);
    c20 = $signed(coeffs.c20);
    c21 = $signed(coeffs.c21);
    c30 = $signed(coeffs.c30);
    p = scale_raw(raw_p, coeffs.p_osr, clip);
    t = scale_raw(raw_t, coeffs.t_osr, clip);
    a2 = c20 * ONE + round_mul(p, c30, 0, clip);
    a1 = c10 * ONE + round_mul(p, a2, FRAC, clip);
    b = c11 * ONE + round_mul(p, c21, 0, clip);
    tp = round_mul(t, p, FRAC, clip);
    p_term = round_mul(p, a1, 2 * FRAC - 6, clip);
    t_term = round_mul(t, c01, FRAC - 6, clip);
    tp_term = round_mul(tp, b, 2 * FRAC - 6, clip);
    pr = c00 * 64 + p_term + t_term + tp_term;
    tm = c0 * 128 + round_mul(t, c1, FRAC - 8, clip);
    if (pr > 64'sd2147483647) begin
      pr = 64'sd2147483647;
      clip = 1'b1;
    end
    if (pr < -64'sd2147483648) begin
      pr = -64'sd2147483648;
      clip = 1'b1;
    end
    if (tm > 64'sd8388607) begin
      tm = 64'sd8388607;
      clip = 1'b1;
    end
    if (tm < -64'sd8388608) begin
      tm = -64'sd8388608;
      clip = 1'b1;
    end
    res.pressure = pr[OUTP_W-1:0];
    res.temperature = tm[OUTT_W-1:0];
    res.saturated = clip;
    return res;
  endfunction

  task automatic flag_mismatch(string what, reading_t want, reading_t got);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= 10)
      $display("%0t mismatch (%s): expected p=%0d t=%0d sat=%0b, got p=%0d t=%0d sat=%0b",
               $realtime, what, $signed(want.pressure), $signed(want.temperature),
               want.saturated, $signed(got.pressure), $signed(got.temperature), got.saturated);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want, got;
    if (!rst_ni) begin
      coeffs <= '0;
      expected_readings.delete();
      mismatch_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (ptc_reg_e'(cfg_idx_i))
          REG_TEMP_COEFFS: {coeffs.c0, coeffs.c1} <= cfg_wdata_i[23:0];
          REG_PRESS_A:     {coeffs.c00, coeffs.c10} <= cfg_wdata_i[39:0];
          REG_PRESS_B:     {coeffs.c01, coeffs.c11} <= cfg_wdata_i[31:0];
          REG_PRESS_C:     {coeffs.c20, coeffs.c21, coeffs.c30} <= cfg_wdata_i[47:0];
          REG_PRESS_OSR:   coeffs.p_osr <= cfg_wdata_i[OSR_W-1:0];
          REG_TEMP_OSR:    coeffs.t_osr <= cfg_wdata_i[OSR_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.pressure = m_axis_tdata[OUTP_W-1:0];
        got.temperature = m_axis_tdata[OUTP_W+OUTT_W-1:OUTP_W];
        got.saturated = m_axis_tuser;
        if (expected_readings.size() == 0) begin
          flag_mismatch("unexpected beat", '0, got);
        end else begin
          want = expected_readings.pop_front();
          if (want.pressure !== got.pressure || want.temperature !== got.temperature ||
              want.saturated !== got.saturated)
            flag_mismatch("field", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(compensate(s_axis_tdata[RAW_W-1:0],
                                               s_axis_tdata[2*RAW_W-1:RAW_W]));
      pending_o = expected_readings.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the compensation testbench: clock, reset, register loads, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam int LATENCY = 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEMS_PER_PHASE = 240;

  typedef enum int {COEF_TYPICAL, COEF_RANDOM, COEF_MAX, COEF_MIN} coef_set_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [2*RAW_W-1:0]       s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUTP_W+OUTT_W-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;
  int                       mismatches;
  int                       pending;
  int unsigned              cycle_cnt = 0;
  int                       burst_left = 20;
  logic [15:0]              ready_pattern = '1;

  pressure_temperature_compensation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  compensation_checker scoreboard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output side: tready steps through a 16-bit ready pattern that is redrawn periodically, sometimes never stalling
  always @(posedge clk_i) begin
    if (cycle_cnt % 48 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= '1;
        1:       ready_pattern <= 16'($urandom);
        2:       ready_pattern <= 16'($urandom & $urandom);
        default: ready_pattern <= 16'($urandom | $urandom);
      endcase
    end
    m_axis_tready <= ready_pattern[cycle_cnt % 16];
  end

  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 8191)) - 24'd4096;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 24'h7FFFFF;
          1:       return 24'h800000;
          2:       return '0;
          default: return '1;
        endcase
      end
      2: return 24'($signed($urandom) >>> $urandom_range(8, 31));
      default: return 24'($urandom);
    endcase
  endfunction

  // valid stays high across a burst; it drops after the last beat of a burst
  task automatic send_reading(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t, bit last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {raw_t, raw_p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    if (last || burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      if (!last) repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(ptc_reg_e idx, logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_config(coef_set_e kind, logic [OSR_W-1:0] p_osr, logic [OSR_W-1:0] t_osr);
    logic [23:0] temp_c;
    logic [39:0] press_a;
    logic [31:0] press_b;
    logic [47:0] press_c;
    case (kind)
      COEF_MAX: begin
        temp_c = {12'h7FF, 12'h7FF};
        press_a = {20'h7FFFF, 20'h7FFFF};
        press_b = {16'h7FFF, 16'h7FFF};
        press_c = {3{16'h7FFF}};
      end
      COEF_MIN: begin
        temp_c = {12'h800, 12'h800};
        press_a = {20'h80000, 20'h80000};
        press_b = {16'h8000, 16'h8000};
        press_c = {3{16'h8000}};
      end
      COEF_RANDOM: begin
        temp_c = 24'($urandom);
        press_a = {8'($urandom), 32'($urandom)};
        press_b = $urandom;
        press_c = {16'($urandom), 32'($urandom)};
      end
      default: begin
        temp_c = {12'(int'($urandom_range(150, 250))), 12'(-int'($urandom_range(200, 300)))};
        press_a = {20'(int'($urandom_range(60000, 90000))),
                   20'(-int'($urandom_range(40000, 60000)))};
        press_b = {16'(-int'($urandom_range(1000, 2000))), 16'(int'($urandom_range(1000, 2000)))};
        press_c = {16'(-int'($urandom_range(10000, 15000))), 16'(int'($urandom_range(50, 150))),
                   16'(-int'($urandom_range(500, 1000)))};
      end
    endcase
    // bits above each register width are junk that the block has to ignore
    write_reg(REG_TEMP_COEFFS, {24'($urandom), temp_c});
    write_reg(REG_PRESS_A, {8'($urandom), press_a});
    write_reg(REG_PRESS_B, {16'($urandom), press_b});
    write_reg(REG_PRESS_C, press_c);
    write_reg(REG_PRESS_OSR, {13'($urandom), 32'($urandom), p_osr});
    write_reg(REG_TEMP_OSR, {13'($urandom), 32'($urandom), t_osr});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    coef_set_e kind;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coefficients still at reset: everything comes out zero
    send_reading(24'h7FFFFF, 24'h800000, 1'b0);
    send_reading(24'h800000, 24'h7FFFFF, 1'b0);
    send_reading(24'h123456, 24'hFEDCBA, 1'b1);
    wait_idle();

    // largest coefficients and largest reciprocal: full-scale readings clamp the temperature
    load_config(COEF_MAX, 3'd4, 3'd4);
    send_reading(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_reading(24'h800000, 24'h800000, 1'b0);
    send_reading(24'h7FFFFF, 24'h800000, 1'b0);
    send_reading(24'h800000, 24'h7FFFFF, 1'b0);
    send_reading(24'h000000, 24'h000000, 1'b0);
    send_reading(24'h000001, 24'hFFFFFF, 1'b1);
    wait_idle();

    load_config(COEF_MIN, 3'd7, 3'd0);
    send_reading(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_reading(24'h800000, 24'h800000, 1'b0);
    send_reading(24'h7FFFFF, 24'h800000, 1'b0);
    send_reading(24'h800000, 24'h7FFFFF, 1'b1);
    wait_idle();

    load_config(COEF_TYPICAL, 3'd3, 3'd5);
    send_reading(24'h555555, 24'hAAAAAA, 1'b0);
    send_reading(24'hAAAAAA, 24'h555555, 1'b0);
    send_reading(24'h000000, 24'h000000, 1'b0);
    send_reading(24'hFFFFFF, 24'h000001, 1'b0);
    send_reading(24'h7FFFFF, 24'h7FFFFF, 1'b1);
    wait_idle();

    // random phases walk both oversampling codes through all eight values
    for (int ph = 0; ph < 8; ph++) begin
      kind = (ph == 3) ? COEF_MAX : (ph == 6) ? COEF_MIN :
             (ph % 2 == 1) ? COEF_RANDOM : COEF_TYPICAL;
      load_config(kind, 3'(ph), 3'(ph * 5 + 2));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_reading(random_raw(), random_raw(),
                     n == ITEMS_PER_PHASE - 1 || (ph == 2 && n == ITEMS_PER_PHASE / 2));
        // hold the input off until the pipeline has fully drained
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end

    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_wide_mul.sv
hw/rtl/ptc_front.sv
hw/rtl/pressure_temperature_compensation.sv
tb/sv/compensation_checker.sv
tb/sv/testbench.sv
